[sv/pkrc_pkg.sv]
// shared widths, command codes and register indexes for the position keeper
package pkrc_pkg;

    localparam int PRICE_BITS   = 31;
    localparam int QTY_BITS     = 24;
    localparam int ACC_BITS     = 64;
    localparam int HALF_BITS    = ACC_BITS / 2;
    localparam int LIMIT_BITS   = ACC_BITS - 1;
    localparam int CMD_BITS     = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int DIV_CNT_BITS = $clog2(ACC_BITS);
    localparam int STEP_BITS    = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_FILL    = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_MARK    = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STARTING_CASH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POSITION_LIMIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOTIONAL_LIMIT = 2'd2;

    // partial products of a wrapped 64 x 64 multiply
    localparam logic [STEP_BITS-1:0] STEP_LO_LO = 2'd0;
    localparam logic [STEP_BITS-1:0] STEP_HI_LO = 2'd1;
    localparam logic [STEP_BITS-1:0] STEP_LO_HI = 2'd2;

endpackage

[sv/pkrc_div.sv]
// radix-2 restoring divider, unsigned 64 by 64, one quotient bit per cycle
module pkrc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pkrc_pkg::ACC_BITS-1:0] i_dividend,
    input  logic [pkrc_pkg::ACC_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [pkrc_pkg::ACC_BITS-1:0] o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [pkrc_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic [pkrc_pkg::ACC_BITS-1:0]     r_rem;
    logic [pkrc_pkg::ACC_BITS-1:0]     r_quo;
    logic [pkrc_pkg::ACC_BITS-1:0]     r_div;
    logic [pkrc_pkg::ACC_BITS:0]       rem_sh;
    logic [pkrc_pkg::ACC_BITS:0]       rem_diff;
    logic [pkrc_pkg::ACC_BITS-1:0]     n_rem;
    logic [pkrc_pkg::ACC_BITS-1:0]     n_quo;

    always_comb begin
        rem_sh   = {r_rem, r_quo[pkrc_pkg::ACC_BITS-1]};
        rem_diff = rem_sh - {1'b0, r_div};
        if (!rem_diff[pkrc_pkg::ACC_BITS]) begin
            n_rem = rem_diff[pkrc_pkg::ACC_BITS-1:0];
            n_quo = {r_quo[pkrc_pkg::ACC_BITS-2:0], 1'b1};
        end else begin
            n_rem = rem_sh[pkrc_pkg::ACC_BITS-1:0];
            n_quo = {r_quo[pkrc_pkg::ACC_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pkrc_pkg::DIV_CNT_BITS'(pkrc_pkg::ACC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[sv/position_keeper_with_risk_check.sv]
// position keeper with pre-trade risk check, top level
//
//   channel   direction  handshake          payload
//   config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//   command   in         i_valid / o_stall  i_cmd, i_side, i_price, i_qty
//   result    out        o_valid / i_stall  o_accepted ... o_open_sell_amount
//
// one command at a time through a shared 32x32 multiplier and a radix-2 divider
// release and reserve compute one product; mark and fill compute a second product
// an adding fill also waits for the 64 iterations of the divider
// synchronous active-low reset clears position, cash and reservations
// a finished beat waits in the output register while the next command is taken
module position_keeper_with_risk_check (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pkrc_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [pkrc_pkg::ACC_BITS-1:0]         i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [pkrc_pkg::CMD_BITS-1:0]         i_cmd,
    input  logic                                  i_side,
    input  logic [pkrc_pkg::PRICE_BITS-1:0]       i_price,
    input  logic [pkrc_pkg::QTY_BITS-1:0]         i_qty,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_accepted,
    output logic signed [pkrc_pkg::ACC_BITS-1:0]  o_cash_now,
    output logic signed [pkrc_pkg::ACC_BITS-1:0]  o_net_position,
    output logic [pkrc_pkg::PRICE_BITS-1:0]       o_average_price,
    output logic signed [pkrc_pkg::ACC_BITS-1:0]  o_realised_profit,
    output logic signed [pkrc_pkg::ACC_BITS-1:0]  o_unrealised_profit,
    output logic [pkrc_pkg::LIMIT_BITS-1:0]       o_open_buy_value,
    output logic [pkrc_pkg::LIMIT_BITS-1:0]       o_open_sell_amount
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_ACC   = 9'b000000100,
        S_PLAN  = 9'b000001000,
        S_RSV   = 9'b000010000,
        S_POST  = 9'b000100000,
        S_DIVGO = 9'b001000000,
        S_DIVW  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    function automatic logic [pkrc_pkg::ACC_BITS-1:0] mag(
        input logic [pkrc_pkg::ACC_BITS-1:0] v
    );
        return v[pkrc_pkg::ACC_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [pkrc_pkg::ACC_BITS-1:0] ext_price(
        input logic [pkrc_pkg::PRICE_BITS-1:0] p
    );
        return {{(pkrc_pkg::ACC_BITS - pkrc_pkg::PRICE_BITS){1'b0}}, p};
    endfunction

    function automatic logic [pkrc_pkg::ACC_BITS-1:0] ext_qty(
        input logic [pkrc_pkg::QTY_BITS-1:0] q
    );
        return {{(pkrc_pkg::ACC_BITS - pkrc_pkg::QTY_BITS){1'b0}}, q};
    endfunction

    t_state                              r_state;
    logic [pkrc_pkg::STEP_BITS-1:0]      r_step;
    logic                                r_phase;
    logic                                r_ovalid;

    logic [pkrc_pkg::ACC_BITS-1:0]       r_cash;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_nq;
    logic [pkrc_pkg::PRICE_BITS-1:0]     r_entry;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_real;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_rbuy;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_rsell;
    logic [pkrc_pkg::LIMIT_BITS-1:0]     r_lim_pos;
    logic [pkrc_pkg::LIMIT_BITS-1:0]     r_lim_notl;

    pkrc_pkg::t_cmd                      r_cmd;
    logic                                r_sell;
    logic [pkrc_pkg::PRICE_BITS-1:0]     r_price;
    logic [pkrc_pkg::QTY_BITS-1:0]       r_qty;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_ma;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_mb;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_prod;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_acc;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_notl;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_sum;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_proj;
    logic                                r_same;
    logic                                r_flip;
    logic                                r_flat;
    logic                                r_nfail;
    logic                                r_accd;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_unreal;

    logic                                r_o_accepted;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_o_cash;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_o_nq;
    logic [pkrc_pkg::PRICE_BITS-1:0]     r_o_avg;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_o_real;
    logic [pkrc_pkg::ACC_BITS-1:0]       r_o_unreal;
    logic [pkrc_pkg::LIMIT_BITS-1:0]     r_o_buy;
    logic [pkrc_pkg::LIMIT_BITS-1:0]     r_o_sell;

    logic [pkrc_pkg::HALF_BITS-1:0]      mul_a;
    logic [pkrc_pkg::HALF_BITS-1:0]      mul_b;
    logic [pkrc_pkg::ACC_BITS-1:0]       n_prod;
    logic [pkrc_pkg::ACC_BITS-1:0]       n_acc;

    logic [pkrc_pkg::ACC_BITS-1:0]       price64;
    logic [pkrc_pkg::ACC_BITS-1:0]       qty64;
    logic [pkrc_pkg::ACC_BITS-1:0]       entry64;
    logic [pkrc_pkg::ACC_BITS-1:0]       sq;
    logic [pkrc_pkg::ACC_BITS-1:0]       nw;
    logic [pkrc_pkg::ACC_BITS-1:0]       old_mag;
    logic                                sq_pos;
    logic                                old_pos;
    logic                                same;
    logic [pkrc_pkg::ACC_BITS-1:0]       per;
    logic [pkrc_pkg::ACC_BITS-1:0]       close_amt;
    logic [pkrc_pkg::ACC_BITS-1:0]       cash_fill;
    logic [pkrc_pkg::ACC_BITS-1:0]       rel_sell;
    logic [pkrc_pkg::ACC_BITS-1:0]       rel_buy;
    logic [pkrc_pkg::ACC_BITS-1:0]       proj;
    logic                                nfail;
    logic                                pfail;
    logic [pkrc_pkg::ACC_BITS-1:0]       mark_diff;

    logic                                div_start;
    logic                                div_done;
    logic [pkrc_pkg::ACC_BITS-1:0]       div_dividend;
    logic [pkrc_pkg::ACC_BITS-1:0]       div_divisor;
    logic [pkrc_pkg::ACC_BITS-1:0]       div_quo;
    logic [pkrc_pkg::PRICE_BITS-1:0]     quo_low;
    logic [pkrc_pkg::PRICE_BITS-1:0]     q_fix;

    logic                                out_load;

    // shared multiplier, one 32x32 partial product per pass
    always_comb begin
        case (r_step)
            pkrc_pkg::STEP_LO_LO: begin
                mul_a = r_ma[pkrc_pkg::HALF_BITS-1:0];
                mul_b = r_mb[pkrc_pkg::HALF_BITS-1:0];
            end
            pkrc_pkg::STEP_HI_LO: begin
                mul_a = r_ma[pkrc_pkg::ACC_BITS-1:pkrc_pkg::HALF_BITS];
                mul_b = r_mb[pkrc_pkg::HALF_BITS-1:0];
            end
            pkrc_pkg::STEP_LO_HI: begin
                mul_a = r_ma[pkrc_pkg::HALF_BITS-1:0];
                mul_b = r_mb[pkrc_pkg::ACC_BITS-1:pkrc_pkg::HALF_BITS];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = pkrc_pkg::ACC_BITS'(mul_a) * pkrc_pkg::ACC_BITS'(mul_b);
        if (r_step == pkrc_pkg::STEP_LO_LO) begin
            n_acc = r_prod;
        end else begin
            n_acc = r_acc + {r_prod[pkrc_pkg::HALF_BITS-1:0], {pkrc_pkg::HALF_BITS{1'b0}}};
        end
    end

    always_comb begin
        price64   = ext_price(r_price);
        qty64     = ext_qty(r_qty);
        entry64   = ext_price(r_entry);
        sq        = r_sell ? (~qty64 + 1'b1) : qty64;
        nw        = r_nq + sq;
        old_mag   = mag(r_nq);
        sq_pos    = !r_sell && (r_qty != '0);
        old_pos   = !r_nq[pkrc_pkg::ACC_BITS-1] && (r_nq != '0);
        same      = (r_nq == '0) || (old_pos == sq_pos);
        per       = r_nq[pkrc_pkg::ACC_BITS-1] ? (entry64 - price64) : (price64 - entry64);
        close_amt = (qty64 < old_mag) ? qty64 : old_mag;
        cash_fill = r_sell ? (r_cash + r_acc) : (r_cash - r_acc);
        rel_sell  = r_rsell - qty64;
        rel_buy   = r_rbuy - r_acc;
        proj      = r_sell ? (r_nq - qty64) : (r_nq + qty64);
        nfail     = (r_lim_notl != '0) && (r_acc > {1'b0, r_lim_notl});
        pfail     = (r_lim_pos != '0) && (mag(r_proj) > {1'b0, r_lim_pos});
        mark_diff = price64 - entry64;
    end

    assign div_start    = (r_state == S_DIVGO) && (r_nq != '0);
    assign div_dividend = mag(r_sum);
    assign div_divisor  = mag(r_nq);
    assign quo_low      = div_quo[pkrc_pkg::PRICE_BITS-1:0];
    assign q_fix        = r_sum[pkrc_pkg::ACC_BITS-1] ? (~quo_low + 1'b1) : quo_low;

    pkrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign out_load = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    // sequencer and account state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= pkrc_pkg::STEP_LO_LO;
            r_phase    <= 1'b0;
            r_ovalid   <= 1'b0;
            r_cash     <= '0;
            r_nq       <= '0;
            r_entry    <= '0;
            r_real     <= '0;
            r_rbuy     <= '0;
            r_rsell    <= '0;
            r_lim_pos  <= '0;
            r_lim_notl <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pkrc_pkg::CFG_STARTING_CASH:  r_cash <= i_cfg_data;
                    pkrc_pkg::CFG_POSITION_LIMIT: r_lim_pos <= i_cfg_data[pkrc_pkg::LIMIT_BITS-1:0];
                    pkrc_pkg::CFG_NOTIONAL_LIMIT: r_lim_notl <= i_cfg_data[pkrc_pkg::LIMIT_BITS-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_step  <= pkrc_pkg::STEP_LO_LO;
                        r_phase <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    if (r_step == pkrc_pkg::STEP_LO_HI) begin
                        r_step  <= pkrc_pkg::STEP_LO_LO;
                        r_state <= r_phase ? S_POST : S_PLAN;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_PLAN: begin
                    case (r_cmd)
                        pkrc_pkg::CMD_FILL: begin
                            r_cash  <= cash_fill;
                            r_nq    <= nw;
                            r_phase <= 1'b1;
                            r_state <= S_MUL;
                        end
                        pkrc_pkg::CMD_RESERVE: r_state <= S_RSV;
                        pkrc_pkg::CMD_RELEASE: begin
                            if (r_sell) begin
                                r_rsell <= rel_sell[pkrc_pkg::ACC_BITS-1] ? '0 : rel_sell;
                            end else begin
                                r_rbuy <= rel_buy[pkrc_pkg::ACC_BITS-1] ? '0 : rel_buy;
                            end
                            r_state <= S_DONE;
                        end
                        pkrc_pkg::CMD_MARK: begin
                            r_phase <= 1'b1;
                            r_state <= S_MUL;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_RSV: begin
                    if (!r_nfail && !pfail) begin
                        if (r_sell) begin
                            r_rsell <= r_rsell + qty64;
                        end else begin
                            r_rbuy <= r_rbuy + r_notl;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_POST: begin
                    if (r_cmd == pkrc_pkg::CMD_FILL && r_same) begin
                        r_state <= S_DIVGO;
                    end else begin
                        if (r_cmd == pkrc_pkg::CMD_FILL) begin
                            r_real <= r_real + r_acc;
                            if (r_flat) begin
                                r_entry <= '0;
                            end else if (r_flip) begin
                                r_entry <= r_price;
                            end
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DIVGO: begin
                    if (r_nq == '0) begin
                        r_entry <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_entry <= q_fix;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // operands, scratch values and the output beat
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_cmd    <= pkrc_pkg::t_cmd'(i_cmd);
                    r_sell   <= i_side;
                    r_price  <= i_price;
                    r_qty    <= i_qty;
                    r_ma     <= ext_price(i_price);
                    r_mb     <= ext_qty(i_qty);
                    r_accd   <= 1'b1;
                    r_unreal <= '0;
                end
            end
            S_MUL: r_prod <= n_prod;
            S_ACC: r_acc <= n_acc;
            S_PLAN: begin
                r_notl  <= r_acc;
                r_nfail <= nfail;
                r_proj  <= proj;
                r_same  <= same;
                r_flip  <= qty64 > old_mag;
                r_flat  <= nw == '0;
                if (r_cmd == pkrc_pkg::CMD_MARK) begin
                    r_ma <= mark_diff;
                    r_mb <= r_nq;
                end else if (same) begin
                    r_ma <= entry64;
                    r_mb <= old_mag;
                end else begin
                    r_ma <= per;
                    r_mb <= close_amt;
                end
            end
            S_RSV: r_accd <= !(r_nfail || pfail);
            S_POST: begin
                r_sum <= r_acc + r_notl;
                if (r_cmd == pkrc_pkg::CMD_MARK) begin
                    r_unreal <= (r_price == '0) ? '0 : r_acc;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_o_accepted <= r_accd;
            r_o_cash     <= r_cash;
            r_o_nq       <= r_nq;
            r_o_avg      <= r_entry;
            r_o_real     <= r_real;
            r_o_unreal   <= r_unreal;
            r_o_buy      <= r_rbuy[pkrc_pkg::LIMIT_BITS-1:0];
            r_o_sell     <= r_rsell[pkrc_pkg::LIMIT_BITS-1:0];
        end
    end

    assign o_stall             = (r_state != S_IDLE);
    assign o_valid             = r_ovalid;
    assign o_accepted          = r_o_accepted;
    assign o_cash_now          = r_o_cash;
    assign o_net_position      = r_o_nq;
    assign o_average_price     = r_o_avg;
    assign o_realised_profit   = r_o_real;
    assign o_unrealised_profit = r_o_unreal;
    assign o_open_buy_value    = r_o_buy;
    assign o_open_sell_amount  = r_o_sell;

endmodule

[sv/pkrc_checker.sv]
// port-level checks for the position keeper, bound to the top level
module pkrc_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_stall,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic                                  o_accepted,
    input logic signed [pkrc_pkg::ACC_BITS-1:0]  o_cash_now,
    input logic signed [pkrc_pkg::ACC_BITS-1:0]  o_net_position,
    input logic signed [pkrc_pkg::ACC_BITS-1:0]  o_realised_profit,
    input logic signed [pkrc_pkg::ACC_BITS-1:0]  o_unrealised_profit
);

    // a taken command keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a command beat");

    // a new result beat only follows a cycle of work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat appeared without work");

    // only a reserve can be refused, and a reserve reports no mark value
    a_refuse_only_reserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_accepted || o_unrealised_profit == '0))
        else $error("refused beat carries a mark value");

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_cash_now)
            && $stable(o_net_position) && $stable(o_realised_profit)))
        else $error("stalled result beat changed");

endmodule

bind position_keeper_with_risk_check pkrc_checker u_pkrc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_accepted          (o_accepted),
    .o_cash_now          (o_cash_now),
    .o_net_position      (o_net_position),
    .o_realised_profit   (o_realised_profit),
    .o_unrealised_profit (o_unrealised_profit)
);
